// ===== sv/bezier_curve_flattener_unit_assert.svh =====
// Assertion macros shared by the flattener RTL.
`ifndef BEZIER_CURVE_FLATTENER_UNIT_ASSERT_SVH
`define BEZIER_CURVE_FLATTENER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bcf_pkg;
  localparam int PT_W        = 32;
  localparam int STEPS_W     = 7;
  localparam int STEPS_RESET = 16;
  localparam int COEF_W      = 40;
  localparam int QUOT_W      = 32;
endpackage
`default_nettype wire

// ===== sv/bcf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bcf_seg_if import bcf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   is_cubic;
  logic signed [PT_W-1:0] start_x;
  logic signed [PT_W-1:0] start_y;
  logic signed [PT_W-1:0] ctrl1_x;
  logic signed [PT_W-1:0] ctrl1_y;
  logic signed [PT_W-1:0] ctrl2_x;
  logic signed [PT_W-1:0] ctrl2_y;
  logic signed [PT_W-1:0] end_x;
  logic signed [PT_W-1:0] end_y;
  modport src (output valid, is_cubic, start_x, start_y, ctrl1_x, ctrl1_y,
               ctrl2_x, ctrl2_y, end_x, end_y, input ready);
  modport snk (input valid, is_cubic, start_x, start_y, ctrl1_x, ctrl1_y,
               ctrl2_x, ctrl2_y, end_x, end_y, output ready);
endinterface

interface bcf_pt_if import bcf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic                   last_point;
  modport src (output valid, point_x, point_y, last_point, input ready);
  modport snk (input valid, point_x, point_y, last_point, output ready);
endinterface

interface bcf_cfg_if import bcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STEPS_W-1:0] data;
  modport src (output valid, data, input ready);
  modport snk (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/bezier_curve_flattener_unit.sv =====
// Bezier segment flattener.
// The seg channel takes one cubic or quadratic segment per request (start,
// controls, end in signed Q16.16). The pt channel returns n points for it,
// n being curve_steps clamped to 1 .. MAX_STEPS: the curve at t = i/n for
// i = 1 .. n-1, then the exact end point with last_point set.
// The cfg channel writes curve_steps; it is always ready and must only be
// written while the block is idle.
// Setup runs on one shared multiply-add unit that builds the forward
// differences for x and y. Each inner point then advances the differences
// once and makes two passes through a shared restoring divider (x, then y);
// the divider sets the cost of each inner point.
// seg.ready is high only while no segment is in work. Results leave through
// an output register; when the receiver stalls the sequencer waits with the
// next point until the register frees, and nothing is dropped.
// Reset (rst, synchronous) sets curve_steps to 16 and empties the block.
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_curve_flattener_unit_assert.svh"
module bezier_curve_flattener_unit import bcf_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input wire logic clk,
  input wire logic rst,
  bcf_cfg_if.snk   cfg,
  bcf_seg_if.snk   seg,
  bcf_pt_if.src    pt
);
  // Widths that follow from the largest step count.
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int DNW = 3 * SW;
  localparam int NW  = 34 + 3 * SW;
  localparam int DW  = NW + 1;
  localparam int RW  = 3 * SW + 1;
  localparam int FW  = SW + 2;
  localparam int CNT_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_ADV, S_DLOAD, S_DIV, S_EMIT, S_END
  } state_t;

  state_t                 state;
  logic [STEPS_W-1:0]     steps;
  logic [SW-1:0]          n_cur;
  logic                   cubic;
  logic [DNW-1:0]         den;
  logic signed [PT_W-1:0] px [4];
  logic signed [PT_W-1:0] py [4];
  logic [NW-1:0]          dx [4];
  logic [NW-1:0]          dy [4];
  logic [NW-1:0]          tmp;
  logic [2:0]             sstep;
  logic                   axis;
  logic [SW-1:0]          idx;
  logic                   div_y;
  logic                   neg;
  logic [CNT_W-1:0]       div_cnt;
  logic [RW-1:0]          rem;
  logic [QUOT_W-1:0]      qr;
  logic [PT_W-1:0]        rx;
  logic                   pt_valid;
  logic [PT_W-1:0]        pt_x;
  logic [PT_W-1:0]        pt_y;
  logic                   pt_last;

  // Configuration register, always able to take a write.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= STEPS_W'(STEPS_RESET);
    end else if (cfg.valid) begin
      steps <= cfg.data;
    end
  end

  // Effective step count: zero acts as one, large values clamp.
  logic [SW-1:0] n_eff;
  always_comb begin
    if (steps == '0) begin
      n_eff = SW'(1);
    end else if (int'(steps) > MAX_STEPS) begin
      n_eff = SW'(MAX_STEPS);
    end else begin
      n_eff = SW'(steps);
    end
  end

  // Polynomial coefficients of the selected axis.
  logic signed [COEF_W-1:0] p0, p1, p2, p3, d10, c0, c1, c2, c3, c3x6;
  always_comb begin
    p0   = COEF_W'(axis ? py[0] : px[0]);
    p1   = COEF_W'(axis ? py[1] : px[1]);
    p2   = COEF_W'(axis ? py[2] : px[2]);
    p3   = COEF_W'(axis ? py[3] : px[3]);
    d10  = p1 - p0;
    c0   = p0;
    c1   = cubic ? (d10 <<< 1) + d10 : (d10 <<< 1);
    c2   = cubic ? ((p0 - (p1 <<< 1) + p2) <<< 1) + (p0 - (p1 <<< 1) + p2)
                 : p0 - (p1 <<< 1) + p3;
    c3   = cubic ? p3 - (p2 <<< 1) - p2 + (p1 <<< 1) + p1 - p0 : '0;
    c3x6 = (c3 <<< 2) + (c3 <<< 1);
  end

  // Shared multiply-add unit: r = a * f + b, kept modulo 2^NW.
  logic signed [NW-1:0]   mac_a;
  logic [FW-1:0]          mac_f;
  logic [NW-1:0]          mac_b;
  logic signed [NW+FW:0]  prod;
  logic [NW-1:0]          mac_r;
  always_comb begin
    mac_a = $signed(tmp);
    mac_f = FW'(n_cur);
    mac_b = '0;
    case (sstep)
      3'd0: begin
        mac_a = NW'(c0);
      end
      3'd2: begin
        mac_f = cubic ? FW'(n_cur) : FW'(1);
      end
      3'd3: begin
        mac_a = NW'(c1);
        mac_b = NW'(c2);
      end
      3'd4: begin
        mac_f = cubic ? FW'(n_cur) : FW'(1);
        mac_b = NW'(c3);
      end
      3'd5: begin
        mac_a = NW'(c2);
        mac_f = cubic ? FW'({n_cur, 1'b0}) : FW'(2);
        mac_b = NW'(c3x6);
      end
      default: begin
      end
    endcase
    prod  = mac_a * $signed({1'b0, mac_f});
    mac_r = prod[NW-1:0] + mac_b;
  end

  // Divider front end: floor((2N + den) / 2den) via one's complement.
  logic [NW-1:0]      num;
  logic signed [DW-1:0] n2;
  logic [DW-1:0]      u;
  logic [RW:0]        tr;
  logic [RW:0]        d2;
  logic               ge;
  logic [QUOT_W-1:0]  q_next;
  logic [PT_W-1:0]    q_res;
  always_comb begin
    num    = div_y ? dy[0] : dx[0];
    n2     = $signed({num, 1'b0}) + $signed(DW'(den));
    u      = n2[DW-1] ? ~n2 : n2;
    tr     = {rem, qr[QUOT_W-1]};
    d2     = (RW+1)'({den, 1'b0});
    ge     = (tr >= d2);
    q_next = {qr[QUOT_W-2:0], ge};
    q_res  = neg ? ~q_next : q_next;
  end

  logic slot_free;
  assign slot_free = !pt_valid || pt.ready;

  // A point is loaded into the output register this cycle.
  logic pt_load;
  assign pt_load = slot_free && (state inside {S_EMIT, S_END});

  assign seg.ready     = (state == S_IDLE);
  assign pt.valid      = pt_valid;
  assign pt.point_x    = pt_x;
  assign pt.point_y    = pt_y;
  assign pt.last_point = pt_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pt_valid <= 1'b0;
      sstep    <= '0;
      axis     <= 1'b0;
      idx      <= '0;
      div_y    <= 1'b0;
      div_cnt  <= '0;
    end else begin
      if (pt_load) begin
        pt_valid <= 1'b1;
      end else if (pt.ready) begin
        pt_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            cubic <= seg.is_cubic;
            n_cur <= n_eff;
            den   <= DNW'(n_eff) * DNW'(n_eff);
            px[0] <= seg.start_x;
            py[0] <= seg.start_y;
            px[1] <= seg.ctrl1_x;
            py[1] <= seg.ctrl1_y;
            px[2] <= seg.ctrl2_x;
            py[2] <= seg.ctrl2_y;
            px[3] <= seg.end_x;
            py[3] <= seg.end_y;
            sstep <= '0;
            axis  <= 1'b0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (sstep == 3'd0 && !axis && cubic) begin
            den <= den * DNW'(n_cur);
          end
          case (sstep)
            3'd2: begin
              if (axis) dy[0] <= mac_r; else dx[0] <= mac_r;
            end
            3'd4: begin
              if (axis) dy[1] <= mac_r; else dx[1] <= mac_r;
            end
            3'd5: begin
              if (axis) begin
                dy[2] <= mac_r;
                dy[3] <= NW'(c3x6);
              end else begin
                dx[2] <= mac_r;
                dx[3] <= NW'(c3x6);
              end
            end
            default: begin
              tmp <= mac_r;
            end
          endcase
          if (sstep == 3'd5) begin
            sstep <= '0;
            axis  <= 1'b1;
            if (axis) begin
              idx   <= SW'(1);
              state <= (n_cur == SW'(1)) ? S_END : S_ADV;
            end
          end else begin
            sstep <= sstep + 3'd1;
          end
        end
        S_ADV: begin
          dx[0] <= dx[0] + dx[1];
          dx[1] <= dx[1] + dx[2];
          dx[2] <= dx[2] + dx[3];
          dy[0] <= dy[0] + dy[1];
          dy[1] <= dy[1] + dy[2];
          dy[2] <= dy[2] + dy[3];
          div_y <= 1'b0;
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          neg     <= n2[DW-1];
          rem     <= u[QUOT_W +: RW];
          qr      <= u[QUOT_W-1:0];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= ge ? RW'(tr - d2) : RW'(tr);
          qr      <= q_next;
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(QUOT_W - 1)) begin
            if (div_y) begin
              state <= S_EMIT;
            end else begin
              rx    <= q_res;
              div_y <= 1'b1;
              state <= S_DLOAD;
            end
          end
        end
        S_EMIT: begin
          // qr holds the y quotient, neg its sign.
          if (slot_free) begin
            pt_x     <= rx;
            pt_y     <= neg ? ~qr : qr;
            pt_last  <= 1'b0;
            idx      <= idx + SW'(1);
            state    <= (idx == n_cur - SW'(1)) ? S_END : S_ADV;
          end
        end
        S_END: begin
          if (slot_free) begin
            pt_x     <= px[3];
            pt_y     <= py[3];
            pt_last  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BCF_ASSERT_NEXT(a_busy_after_req, seg.valid && seg.ready, !seg.ready, "ready after request")
  `BCF_ASSERT_NEXT(a_end_loaded, state == S_END && slot_free, pt.valid && pt.last_point, "end point lost")
  `BCF_ASSERT_NOW(a_idx_range, state == S_ADV, idx != '0 && idx < n_cur, "point index out of range")

endmodule
`default_nettype wire
